>>> rtl/ppc_pkg.sv
// Shared constants, types and the rounded multiply of the pixel compositor.
package ppc_pkg;

	localparam int MAX_CHANNELS = 4;
	localparam int NUM_CH = 4;
	localparam int ACT_MAX = (MAX_CHANNELS < NUM_CH) ? MAX_CHANNELS : NUM_CH;

	localparam int CH_W = 8;
	localparam int CNT_W = 3;
	localparam int MODE_W = 2;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_BLEND_MODE = 2'd0;
	localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

	localparam logic [CNT_W-1:0] CNT_RESET = 3'd4;
	localparam logic [CNT_W-1:0] CNT_MIN = 3'd1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ACT_MAX);

	localparam logic [CH_W-1:0] CH_FULL = 8'hFF;

	typedef enum logic [MODE_W-1:0] {
		MODE_OVER = 2'd0,
		MODE_OVER_ALPHA = 2'd1,
		MODE_MASK = 2'd2
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic active;
		logic is_alpha;
	} lane_ctl_t;

	// a * b / 255, rounded
	function automatic logic [CH_W-1:0] mul255(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] b);
		logic [2*CH_W-1:0] t;
		logic [2*CH_W-1:0] u;
		t = {8'd0, a} * {8'd0, b} + 16'd128;
		u = t + {8'd0, t[2*CH_W-1:CH_W]};
		return u[2*CH_W-1:CH_W];
	endfunction

endpackage

>>> rtl/ppc_lane.sv
// One channel lane: blend, mask or pass the destination through.
module ppc_lane import ppc_pkg::*; (
	input  lane_ctl_t       ctl,
	input  logic [CH_W-1:0] src,
	input  logic [CH_W-1:0] dst,
	input  logic [CH_W-1:0] src_alpha,
	input  logic [CH_W-1:0] mask,
	output logic [CH_W-1:0] result
);

	logic [CH_W-1:0] op_a;
	logic [CH_W-1:0] op_b;
	logic [CH_W-1:0] addend;
	logic [CH_W-1:0] prod;
	logic [CH_W:0]   sum;
	logic            pass;

	always_comb begin
		op_a = dst;
		op_b = CH_FULL - src_alpha;
		addend = '0;
		pass = 1'b0;
		unique case (ctl.mode)
			MODE_OVER: begin
				addend = src;
			end
			MODE_OVER_ALPHA: begin
				addend = ctl.is_alpha ? src : '0;
			end
			MODE_MASK: begin
				op_a = src;
				op_b = mask;
			end
			default: begin
				pass = 1'b1;
			end
		endcase
	end

	assign prod = mul255(op_a, op_b);
	assign sum = {1'b0, addend} + {1'b0, prod};

	always_comb begin
		if (pass || !ctl.active) begin
			result = dst;
		end else if (sum[CH_W]) begin
			result = CH_FULL;
		end else begin
			result = sum[CH_W-1:0];
		end
	end

endmodule

>>> rtl/premultiplied_pixel_compositor_unit.sv
// Top level of the premultiplied pixel compositor: registers, pipeline and lanes.
//
// channel  direction  handshake            word
// in       input      in_valid/in_ready    src_ch0..3, dst_ch0..3, mask_value
// out      output     out_valid/out_ready  out_ch0..3
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel per cycle sustained while out_ready is high; pixels pass from the input register to the result register.
// The four lane multipliers sit between those two registers and set the cycle.
// Reset clears the pipeline valid bits and loads blend_mode 0, channel_count 4.
// A stalled result holds in the output register; the input register keeps
// accepting until both stages are full.
module premultiplied_pixel_compositor_unit import ppc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CH_W-1:0]  src_ch0,
	input  logic [CH_W-1:0]  src_ch1,
	input  logic [CH_W-1:0]  src_ch2,
	input  logic [CH_W-1:0]  src_ch3,
	input  logic [CH_W-1:0]  dst_ch0,
	input  logic [CH_W-1:0]  dst_ch1,
	input  logic [CH_W-1:0]  dst_ch2,
	input  logic [CH_W-1:0]  dst_ch3,
	input  logic [CH_W-1:0]  mask_value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CH_W-1:0]  out_ch0,
	output logic [CH_W-1:0]  out_ch1,
	output logic [CH_W-1:0]  out_ch2,
	output logic [CH_W-1:0]  out_ch3,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0] cfg_data
);

	mode_t            mode_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] act_cnt;

	logic             valid_s1;
	logic [CH_W-1:0]  src_s1 [NUM_CH];
	logic [CH_W-1:0]  dst_s1 [NUM_CH];
	logic [CH_W-1:0]  mask_s1;
	logic             valid_s2;
	logic [CH_W-1:0]  res_s2 [NUM_CH];
	logic [CH_W-1:0]  res    [NUM_CH];

	logic             adv_s1;
	logic             adv_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OVER;
			count_q <= CNT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_BLEND_MODE) begin
				mode_q <= mode_t'(cfg_data[MODE_W-1:0]);
			end else if (cfg_index == REG_CHANNEL_COUNT) begin
				count_q <= cfg_data;
			end
		end
	end

	always_comb begin
		priority if (count_q == '0) begin
			act_cnt = CNT_MIN;
		end else if (count_q > CNT_MAX) begin
			act_cnt = CNT_MAX;
		end else begin
			act_cnt = count_q;
		end
	end

	assign adv_s2 = !valid_s2 || out_ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			src_s1[0] <= src_ch0;
			src_s1[1] <= src_ch1;
			src_s1[2] <= src_ch2;
			src_s1[3] <= src_ch3;
			dst_s1[0] <= dst_ch0;
			dst_s1[1] <= dst_ch1;
			dst_s1[2] <= dst_ch2;
			dst_s1[3] <= dst_ch3;
			mask_s1 <= mask_value;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res;
		end
	end

	for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
		lane_ctl_t ctl;

		assign ctl.mode = mode_q;
		assign ctl.active = (CNT_W'(k) < act_cnt);
		assign ctl.is_alpha = (k == 0);

		ppc_lane u_lane (
			.ctl       (ctl),
			.src       (src_s1[k]),
			.dst       (dst_s1[k]),
			.src_alpha (src_s1[0]),
			.mask      (mask_s1),
			.result    (res[k])
		);
	end

	assign out_valid = valid_s2;
	assign out_ch0 = res_s2[0];
	assign out_ch1 = res_s2[1];
	assign out_ch2 = res_s2[2];
	assign out_ch3 = res_s2[3];

endmodule

>>> rtl/ppc_checker.sv
// Port-level checks of the compositor pipeline, bound to the top level.
module ppc_checker import ppc_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input logic [CH_W-1:0] out_ch0,
	input logic [CH_W-1:0] out_ch1,
	input logic [CH_W-1:0] out_ch2,
	input logic [CH_W-1:0] out_ch3
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_ch0) && $stable(out_ch1)
			&& $stable(out_ch2) && $stable(out_ch3))
		else $error("stalled result word changed");

	a_busy_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while output can drain");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready |=> out_valid)
		else $error("accepted word did not reach the output");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result word without an accepted input word");

endmodule

bind premultiplied_pixel_compositor_unit ppc_checker u_ppc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_ch0   (out_ch0),
	.out_ch1   (out_ch1),
	.out_ch2   (out_ch2),
	.out_ch3   (out_ch3)
);

>>> dv/premultiplied_pixel_compositor_unit_tb.sv
// Self-checking testbench of the premultiplied pixel compositor with a pixel scoreboard.
module premultiplied_pixel_compositor_unit_tb;
	import ppc_pkg::*;

	localparam int RAND_SEGMENTS = 16;
	localparam int SEGMENT_PIXELS = 100;
	localparam int SETTLE_CYCLES = 6;
	localparam int LONG_HOLD = 150;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;

	typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

	typedef struct packed {
		pixel_t src;
		pixel_t dst;
		logic [CH_W-1:0] mask;
	} pix_in_t;

	class pixel_scoreboard;
		pixel_t expected_q[$];
		int mismatches;
		logic [MODE_W-1:0] mode_q;
		logic [CNT_W-1:0] count_q;

		function new();
			mismatches = 0;
			mode_q = MODE_OVER;
			count_q = CNT_RESET;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CNT_W-1:0] data);
			if (idx == REG_BLEND_MODE) begin
				mode_q = data[MODE_W-1:0];
			end else if (idx == REG_CHANNEL_COUNT) begin
				count_q = data;
			end
		endfunction

		function logic [CH_W-1:0] scale255(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
			int unsigned t;
			t = a * b + 128;
			return CH_W'((t + (t >> 8)) >> 8);
		endfunction

		function logic [CH_W-1:0] sat_add(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
			int unsigned s;
			s = a + b;
			return (s > 255) ? CH_FULL : CH_W'(s);
		endfunction

		function pixel_t blend(pix_in_t w);
			pixel_t r;
			int unsigned n;
			logic [CH_W-1:0] inv;
			inv = CH_FULL - w.src[0];
			n = count_q;
			if (n == 0) n = 1;
			if (n > ACT_MAX) n = ACT_MAX;
			for (int k = 0; k < NUM_CH; k++) begin
				r[k] = w.dst[k];
				if (k < n) begin
					case (mode_q)
						MODE_OVER: r[k] = sat_add(w.src[k], scale255(w.dst[k], inv));
						MODE_OVER_ALPHA: begin
							if (k == 0) r[k] = sat_add(w.src[0], scale255(w.dst[0], inv));
							else r[k] = scale255(w.dst[k], inv);
						end
						MODE_MASK: r[k] = scale255(w.src[k], w.mask);
						default: r[k] = w.dst[k];
					endcase
				end
			end
			return r;
		endfunction

		function void note_pixel(pix_in_t w);
			expected_q.push_back(blend(w));
		endfunction

		task report_mismatch(string msg);
			if (mismatches < 100) $display("MISMATCH: %s", msg);
			mismatches++;
		endtask

		task check_pixel(pixel_t got);
			pixel_t exp_px;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel %h", got));
			end else begin
				exp_px = expected_q.pop_front();
				for (int k = 0; k < NUM_CH; k++) begin
					if (got[k] !== exp_px[k])
						report_mismatch($sformatf("out_ch%0d got %h want %h (pixel %h)",
							k, got[k], exp_px[k], exp_px));
				end
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CH_W-1:0] src_ch0 = '0, src_ch1 = '0, src_ch2 = '0, src_ch3 = '0;
	logic [CH_W-1:0] dst_ch0 = '0, dst_ch1 = '0, dst_ch2 = '0, dst_ch3 = '0;
	logic [CH_W-1:0] mask_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CH_W-1:0] out_ch0, out_ch1, out_ch2, out_ch3;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int cycle_cnt = 0;
	pixel_scoreboard sb = new();

	premultiplied_pixel_compositor_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.src_ch0(src_ch0), .src_ch1(src_ch1), .src_ch2(src_ch2), .src_ch3(src_ch3),
		.dst_ch0(dst_ch0), .dst_ch1(dst_ch1), .dst_ch2(dst_ch2), .dst_ch3(dst_ch3),
		.mask_value(mask_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_ch0(out_ch0), .out_ch1(out_ch1), .out_ch2(out_ch2), .out_ch3(out_ch3),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_pixel('{src: {src_ch3, src_ch2, src_ch1, src_ch0},
					dst: {dst_ch3, dst_ch2, dst_ch1, dst_ch0}, mask: mask_value});
			if (out_valid && out_ready) sb.check_pixel({out_ch3, out_ch2, out_ch1, out_ch0});
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task send_pixel(pix_in_t w);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		end
		in_valid <= 1'b1;
		{src_ch3, src_ch2, src_ch1, src_ch0} <= w.src;
		{dst_ch3, dst_ch2, dst_ch1, dst_ch0} <= w.dst;
		mask_value <= w.mask;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task write_reg(logic [IDX_W-1:0] idx, logic [CNT_W-1:0] data);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [CH_W-1:0] rand_byte();
		case ($urandom_range(7))
			0: return '0;
			1: return CH_FULL;
			default: return CH_W'($urandom_range(255));
		endcase
	endfunction

	function automatic pix_in_t rand_pixel();
		pix_in_t w;
		w.src[0] = rand_byte();
		w.dst[0] = rand_byte();
		for (int k = 1; k < NUM_CH; k++) begin
			w.src[k] = ($urandom_range(9) < 7) ? CH_W'($urandom_range(w.src[0])) : rand_byte();
			w.dst[k] = ($urandom_range(9) < 7) ? CH_W'($urandom_range(w.dst[0])) : rand_byte();
		end
		w.mask = rand_byte();
		return w;
	endfunction

	task run_directed();
		send_pixel('{src: '0, dst: '0, mask: '0});
		send_pixel('{src: '0, dst: '1, mask: '1});
		send_pixel('{src: '1, dst: '1, mask: '0});
		send_pixel('{src: {8'hFF, 8'hFF, 8'hFF, 8'h00}, dst: '1, mask: '0});
		send_pixel('{src: {8'h40, 8'h60, 8'h20, 8'h80}, dst: {8'hC0, 8'h10, 8'hF0, 8'h7F},
			mask: 8'h55});
		write_reg(REG_SPARE_2, 3'd7);
		write_reg(REG_SPARE_3, 3'd5);
		send_pixel('{src: {8'h10, 8'h20, 8'h30, 8'h40}, dst: '1, mask: '0});
		write_reg(REG_BLEND_MODE, {1'b1, MODE_OVER_ALPHA});
		send_pixel('{src: {8'hFF, 8'hFF, 8'hFF, 8'hC8}, dst: {8'h20, 8'h40, 8'h80, 8'h64},
			mask: '1});
		send_pixel('{src: '1, dst: '1, mask: '0});
		send_pixel('{src: {8'hAA, 8'h55, 8'hFF, 8'h00}, dst: '1, mask: '0});
		write_reg(REG_BLEND_MODE, {1'b0, MODE_MASK});
		send_pixel('{src: '1, dst: '0, mask: '0});
		send_pixel('{src: '1, dst: '0, mask: '1});
		send_pixel('{src: '1, dst: '1, mask: 8'h80});
		write_reg(REG_BLEND_MODE, {1'b1, MODE_UNDEF});
		send_pixel('{src: '1, dst: {8'h12, 8'h34, 8'h56, 8'h78}, mask: '1});
		write_reg(REG_BLEND_MODE, {1'b0, MODE_OVER});
		write_reg(REG_CHANNEL_COUNT, 3'd0);
		send_pixel('{src: {8'h30, 8'h30, 8'h30, 8'h40}, dst: '1, mask: '0});
		write_reg(REG_CHANNEL_COUNT, 3'd7);
		send_pixel('{src: {8'h30, 8'h30, 8'h30, 8'h40}, dst: '1, mask: '0});
		write_reg(REG_CHANNEL_COUNT, 3'd2);
		send_pixel('{src: {8'h30, 8'h30, 8'h30, 8'h40}, dst: '1, mask: '0});
		write_reg(REG_CHANNEL_COUNT, CNT_MIN);
		send_pixel('{src: {8'h30, 8'h30, 8'h30, 8'h40}, dst: '1, mask: '0});
	endtask

	initial begin
		logic [MODE_W-1:0] mode;
		logic [CNT_W-1:0] cnt;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
			mode = (seg < 8) ? MODE_W'(seg % 4) : MODE_W'($urandom_range(3));
			cnt = (seg < 8) ? CNT_W'((seg * 3) % 8) : CNT_W'($urandom_range(7));
			write_reg(REG_BLEND_MODE, {1'($urandom_range(1)), mode});
			write_reg(REG_CHANNEL_COUNT, cnt);
			if (seg < 5) begin
				send_idle_pct = 22;
				recv_idle_pct = 84;
			end else if (seg < 10) begin
				send_idle_pct = 84;
				recv_idle_pct = 22;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (seg == 10 || seg == 13) hold_left = LONG_HOLD;
			for (int i = 0; i < SEGMENT_PIXELS; i++) send_pixel(rand_pixel());
		end
		wait_drained();
		if (sb.expected_q.size() != 0)
			sb.report_mismatch($sformatf("%0d pixels never came out", sb.expected_q.size()));
		if (sb.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
